>>> design/buffer_drift_corrector_assert.svh
// assertion macros for the buffer drift corrector
`ifndef BUFFER_DRIFT_CORRECTOR_ASSERT_SVH
`define BUFFER_DRIFT_CORRECTOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BDC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdc: %s", "label");
// implication checked in the cycle after the antecedent
`define BDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdc: %s", "label");
`endif

>>> design/bdc_pkg.sv
// ---------------------------------------------------------------------------
// bdc_pkg
// types and constants shared by the buffer drift corrector
// ---------------------------------------------------------------------------
`default_nettype none
package bdc_pkg;
  localparam int MAX_STEP_MS_DEF = 200;
  localparam int FILL_BITS_DEF   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int CreditW  = 40;
  localparam int DivW     = 48;
  localparam int DivCntW  = 6;

  localparam logic [CfgIdxW-1:0] REG_SETTLE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FLOOR   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CEILING = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TAU     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEAD    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAIN    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAXRATE = 3'd6;

  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_DROP    = 2'd1,
    MODE_INSERT  = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CORR_NONE   = 2'd0,
    CORR_DROP   = 2'd1,
    CORR_INSERT = 2'd2
  } corr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FDIV,
    ST_FWAIT,
    ST_SETTLE,
    ST_RMUL,
    ST_RCLAMP,
    ST_CMUL,
    ST_CDIV,
    ST_CWAIT,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [16:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [DivW-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> design/buffer_drift_corrector.sv
// ---------------------------------------------------------------------------
// buffer_drift_corrector
// fill-level tracking with drop and insert requests
// ---------------------------------------------------------------------------
// sequence: confirm, restart and seeding beats pass from idle through done to
// out; an update adds one pass of the shared divider for the level while
// settling and a second pass for the credit after
// throughput: one beat at a time, in_stall is high until the result is taken
// reset: synchronous, active low; all but datapath registers return to defaults
`default_nettype none
module buffer_drift_corrector #(
  parameter int MAX_STEP_MS = bdc_pkg::MAX_STEP_MS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [31:0]                       in_now_ms,
  input  wire logic [bdc_pkg::FILL_BITS_DEF-1:0] in_fill_bytes,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_correction,
  output logic [15:0]                            out_target_level,
  output logic [31:0]                            out_inserted_count,
  output logic [31:0]                            out_dropped_count,
  input  wire logic                              cfg_we,
  input  wire logic [bdc_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [bdc_pkg::CfgDataW-1:0]      cfg_data
);
  import bdc_pkg::*;
  `include "buffer_drift_corrector_assert.svh"

  localparam int LevelW = FILL_BITS_DEF + 16;
  localparam logic [39:0] CMAX = {1'b0, {39{1'b1}}};
  localparam logic [39:0] CMIN = {1'b1, {39{1'b0}}};
  localparam logic [39:0] ONE  = 40'd65536;

  logic [19:0] settle_ms_r;
  logic [15:0] floor_r, ceil_r, tau_r, dead_r;
  logic [23:0] gain_r, maxrate_r;

  state_t st_r, st_nxt;
  logic [1:0]        mode_r;
  logic [31:0]       now_r;
  logic [FILL_BITS_DEF-1:0] fill_r;
  logic [31:0]       last_r;
  logic [LevelW-1:0] level_r, level_nxt;
  logic [39:0]       credit_r, credit_nxt;
  logic [19:0]       settle_r, settle_nxt;
  logic              seeded_r, seeded_nxt;
  logic [15:0]       target_r, target_nxt;
  logic [31:0]       ins_r, drp_r;
  logic [15:0]       dt_r;
  logic              neg_r;
  logic [47:0]       acc_r, acc_nxt;
  logic [1:0]        corr_r, corr_nxt;

  // shared multiplier operands, product registered in acc_r
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;

  div_req_t dreq;
  div_rsp_t drsp;

  bdc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] dt_raw;
  logic [LevelW:0] diff_s;
  logic [LevelW-1:0] diff_mag;
  logic [LevelW+1:0] err_s, dead_s, excess;
  logic [LevelW:0]   ex_mag;
  logic [16:0] rnd;
  logic [16:0] tcal;
  logic [16:0] fden;
  logic [40:0] csum;

  assign dt_raw   = now_r - last_r;
  assign diff_s   = {1'b0, fill_r, 16'h0} - {1'b0, level_r};
  assign diff_mag = diff_s[LevelW] ? LevelW'(-diff_s) : diff_s[LevelW-1:0];
  assign err_s    = {2'b0, level_r} - (LevelW+2)'({target_r, 16'h0});
  assign dead_s   = (LevelW+2)'({dead_r, 16'h0});
  always_comb begin
    if ($signed(err_s) > $signed(dead_s)) excess = err_s - dead_s;
    else if ($signed(err_s) < -$signed(dead_s)) excess = err_s + dead_s;
    else excess = '0;
  end
  assign ex_mag = excess[LevelW+1] ? (LevelW+1)'(-excess) : excess[LevelW:0];
  assign rnd    = 17'((({1'b0, level_r} + (LevelW+1)'(32768)) >> 16));
  always_comb begin
    tcal = rnd;
    if (tcal < {1'b0, floor_r}) tcal = {1'b0, floor_r};
    if (tcal > {1'b0, ceil_r}) tcal = {1'b0, ceil_r};
  end
  // zero time constant and zero step leave the level as it is
  assign fden = {1'b0, tau_r} + 17'(dt_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == ST_FMUL) begin
      mul_a = 32'(diff_mag);
      mul_b = 24'(dt_r);
    end else if (st_r == ST_CMUL) begin
      mul_a = acc_r[31:0];
      mul_b = 24'(dt_r);
    end else begin
      mul_a = 32'(acc_r[LevelW:0]);
      mul_b = gain_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  function automatic logic [39:0] sat40(input logic [40:0] v);
    if (!v[40] && v[39]) sat40 = CMAX;
    else if (v[40] && !v[39]) sat40 = CMIN;
    else sat40 = v[39:0];
  endfunction

  assign csum = (mode_r == MODE_DROP) ? {credit_r[39], credit_r} - {1'b0, ONE}
                                      : {credit_r[39], credit_r} + {1'b0, ONE};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = ST_DONE;
      ST_FMUL:   st_nxt = ST_FDIV;
      ST_FDIV:   st_nxt = ST_FWAIT;
      ST_FWAIT:  if (!drsp.busy) st_nxt = (settle_r != '0) ? ST_SETTLE : ST_RMUL;
      ST_SETTLE: st_nxt = ST_OUT;
      ST_RMUL:   st_nxt = ST_RCLAMP;
      ST_RCLAMP: st_nxt = ST_CMUL;
      ST_CMUL:   st_nxt = ST_CDIV;
      ST_CDIV:   st_nxt = ST_CWAIT;
      ST_CWAIT:  if (!drsp.busy) st_nxt = ST_OUT;
      ST_DONE: begin
        if (mode_r == MODE_UPDATE && seeded_r) st_nxt = ST_FMUL;
        else st_nxt = ST_OUT;
      end
      ST_OUT:    if (!out_stall) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    level_nxt  = level_r;
    credit_nxt = credit_r;
    settle_nxt = settle_r;
    seeded_nxt = seeded_r;
    target_nxt = target_r;
    acc_nxt    = acc_r;
    corr_nxt   = corr_r;
    dreq       = '0;
    unique case (st_r)
      ST_FMUL: acc_nxt = 48'(mul_p);
      ST_FDIV: begin
        dreq.start    = 1'b1;
        dreq.dividend = acc_r;
        dreq.divisor  = (fden == '0) ? 17'd1 : fden;
      end
      ST_FWAIT: if (!drsp.busy) begin
        level_nxt = diff_s[LevelW] ? level_r - LevelW'(drsp.quotient)
                                   : level_r + LevelW'(drsp.quotient);
      end
      ST_SETTLE: begin
        settle_nxt = (20'(dt_r) >= settle_r) ? '0 : settle_r - 20'(dt_r);
        credit_nxt = '0;
        if (20'(dt_r) >= settle_r) target_nxt = tcal[15:0];
      end
      ST_RMUL: acc_nxt = 48'(ex_mag);
      ST_RCLAMP: begin
        acc_nxt = 48'(mul_p >> 16);
        if ((mul_p >> 16) > 56'(maxrate_r)) acc_nxt = 48'(maxrate_r);
      end
      ST_CMUL: acc_nxt = 48'(mul_p);
      ST_CDIV: begin
        dreq.start    = 1'b1;
        dreq.dividend = acc_r;
        dreq.divisor  = 17'd1000;
      end
      ST_CWAIT: if (!drsp.busy) begin
        acc_nxt = drsp.quotient;
      end
      ST_DONE: begin
        corr_nxt = CORR_NONE;
        if (mode_r == MODE_UPDATE && !seeded_r) begin
          level_nxt  = {fill_r, 16'h0};
          seeded_nxt = 1'b1;
        end else if (mode_r == MODE_DROP || mode_r == MODE_INSERT) begin
          credit_nxt = sat40(csum);
        end else if (mode_r == MODE_RESTART) begin
          level_nxt  = '0;
          credit_nxt = '0;
          settle_nxt = settle_ms_r;
          seeded_nxt = 1'b0;
          target_nxt = floor_r;
        end
      end
      default: ;
    endcase
    if (st_r == ST_CWAIT && !drsp.busy) begin
      credit_nxt = sat40(neg_r ? {credit_r[39], credit_r} - {1'b0, drsp.quotient[39:0]}
                               : {credit_r[39], credit_r} + {1'b0, drsp.quotient[39:0]});
      if ($signed(credit_nxt) >= $signed(ONE)) corr_nxt = CORR_DROP;
      else if ($signed(credit_nxt) <= -$signed(ONE)) corr_nxt = CORR_INSERT;
      else corr_nxt = CORR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (st_r == ST_IDLE && in_valid) begin
      mode_r <= in_mode;
      now_r  <= in_now_ms;
      fill_r <= in_fill_bytes;
    end
    if (st_r == ST_DONE) begin
      dt_r <= (dt_raw > 32'(MAX_STEP_MS)) ? 16'(MAX_STEP_MS) : dt_raw[15:0];
    end
    if (st_r == ST_RMUL) neg_r <= excess[LevelW+1];
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      settle_ms_r <= 20'd2000;
      floor_r     <= 16'd4000;
      ceil_r      <= 16'd8000;
      tau_r       <= 16'd2000;
      dead_r      <= 16'd256;
      gain_r      <= 24'd66;
      maxrate_r   <= 24'd327680;
      last_r      <= '0;
      level_r     <= '0;
      credit_r    <= '0;
      settle_r    <= 20'd2000;
      seeded_r    <= 1'b0;
      target_r    <= 16'd4000;
      ins_r       <= '0;
      drp_r       <= '0;
      corr_r      <= CORR_NONE;
    end else begin
      st_r     <= st_nxt;
      level_r  <= level_nxt;
      credit_r <= credit_nxt;
      settle_r <= settle_nxt;
      seeded_r <= seeded_nxt;
      target_r <= target_nxt;
      corr_r   <= corr_nxt;
      if (st_r == ST_DONE) begin
        if (mode_r == MODE_UPDATE || mode_r == MODE_RESTART) last_r <= now_r;
        if (mode_r == MODE_DROP) drp_r <= drp_r + 1'b1;
        if (mode_r == MODE_INSERT) ins_r <= ins_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SETTLE:  settle_ms_r <= cfg_data[19:0];
          REG_FLOOR:   floor_r     <= cfg_data[15:0];
          REG_CEILING: ceil_r      <= cfg_data[15:0];
          REG_TAU:     tau_r       <= cfg_data[15:0];
          REG_DEAD:    dead_r      <= cfg_data[15:0];
          REG_GAIN:    gain_r      <= cfg_data;
          REG_MAXRATE: maxrate_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_stall           = (st_r != ST_IDLE);
  assign out_valid          = (st_r == ST_OUT);
  assign out_correction     = corr_r;
  assign out_target_level   = target_r;
  assign out_inserted_count = ins_r;
  assign out_dropped_count  = drp_r;

  `BDC_ASSERT_IMP(a_one_side, out_valid, in_stall)
  `BDC_ASSERT_IMP(a_corr_code, out_valid, out_correction != 2'd3)
  `BDC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_correction))
  `BDC_ASSERT_IMP(a_corr_update, out_valid && out_correction != CORR_NONE, mode_r == MODE_UPDATE)
endmodule
`default_nettype wire

>>> design/bdc_divider.sv
// ---------------------------------------------------------------------------
// bdc_divider
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module bdc_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bdc_pkg::div_req_t req,
  output bdc_pkg::div_rsp_t      rsp
);
  import bdc_pkg::*;
  `include "buffer_drift_corrector_assert.svh"

  logic [DivW-1:0]    quo_r, quo_nxt;
  logic [17:0]        rem_r, rem_nxt;
  logic [16:0]        dvs_r, dvs_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [17:0]        trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = '0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DivCntW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[16:0], quo_r[DivW-1]};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DivCntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

  `BDC_ASSERT_IMP(a_cnt_busy, busy_r, cnt_r != '0)
  `BDC_ASSERT_NEXT(a_start_busy, req.start, busy_r)
  `BDC_ASSERT_IMP(a_rem_below, busy_r, rem_r < {1'b0, dvs_r})
endmodule
`default_nettype wire
